// ----- rtl/dpod_pkg.sv -----
// Shared types, constants and calendar helpers for the date period overlap block.
// No dependencies; every other file imports this package.
package dpod_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DNUM_W  = 23;  // day number of any 14-bit year
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned LANES   = 4;   // first start/end, second start/end
  localparam int unsigned STAGES  = 4;   // two lane stages plus two merge stages
  localparam int unsigned DIV_W   = 18;  // width of the divide-by-25 reciprocal
  localparam int unsigned DIV_SH  = 22;  // shift that goes with the reciprocal

  // floor(x / 25) = (x * DIV25_RECIP) >> DIV_SH for every x below 7989
  localparam logic [DIV_W-1:0] DIV25_RECIP = 18'd167773;
  localparam logic [14:0]      YEAR_BIAS   = 15'd399;

  // Months by number
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [DNUM_W-1:0] dnum;
    logic              bad;
  } day_res_t;

  // Days in the year before the first of the month; zero for codes with no month
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month in days
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    if (m == MON_FEB) begin
      r = leap ? 5'd29 : 5'd28;
    end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
      r = 5'd30;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

endpackage

// ----- rtl/dpod_in_if.sv -----
// Input channel: valid/ready handshake carrying the two date periods.
// Depends on dpod_pkg for field widths.
interface dpod_in_if import dpod_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  first_start_year;
  logic [MONTH_W-1:0] first_start_month;
  logic [DAY_W-1:0]   first_start_day;
  logic [YEAR_W-1:0]  first_end_year;
  logic [MONTH_W-1:0] first_end_month;
  logic [DAY_W-1:0]   first_end_day;
  logic [YEAR_W-1:0]  second_start_year;
  logic [MONTH_W-1:0] second_start_month;
  logic [DAY_W-1:0]   second_start_day;
  logic [YEAR_W-1:0]  second_end_year;
  logic [MONTH_W-1:0] second_end_month;
  logic [DAY_W-1:0]   second_end_day;

  modport source (
    output valid, first_start_year, first_start_month, first_start_day,
           first_end_year, first_end_month, first_end_day,
           second_start_year, second_start_month, second_start_day,
           second_end_year, second_end_month, second_end_day,
    input  ready
  );

  modport sink (
    input  valid, first_start_year, first_start_month, first_start_day,
           first_end_year, first_end_month, first_end_day,
           second_start_year, second_start_month, second_start_day,
           second_end_year, second_end_month, second_end_day,
    output ready
  );
endinterface

// ----- rtl/dpod_out_if.sv -----
// Output channel: valid/ready handshake carrying the overlap count and date flag.
// Depends on dpod_pkg for field widths.
interface dpod_out_if import dpod_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] overlap_days;
  logic               bad_date;

  modport source (
    output valid, overlap_days, bad_date,
    input  ready
  );

  modport sink (
    input  valid, overlap_days, bad_date,
    output ready
  );
endinterface

// ----- rtl/dpod_date_lane.sv -----
// One date lane: checks a date and turns it into a Gregorian day number.
// Two register stages; depends on dpod_pkg.
module dpod_date_lane import dpod_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  date_t    date_i,
  output day_res_t res_o
);

  // Stage A: bias the year and start both divide-by-25 multiplies
  logic [14:0]          t_yr;
  logic [12:0]          t_q4;
  logic [11:0]          y_q4;
  logic [30:0]          prod_t;
  logic [29:0]          prod_y;

  logic [14:0]          t_q;
  logic [7:0]           t_c100_q;   // (year + 399) / 100
  logic [11:0]          y_q4_q;     // year / 4
  logic [7:0]           y_c100_q;   // (year / 4) / 25
  logic [1:0]           y_lo_q;
  logic [MONTH_W-1:0]   month_q;
  logic [DAY_W-1:0]     day_q;

  assign t_yr   = 15'(date_i.year) + YEAR_BIAS;
  assign t_q4   = t_yr[14:2];
  assign y_q4   = date_i.year[13:2];
  assign prod_t = 31'(t_q4) * 31'(DIV25_RECIP);
  assign prod_y = 30'(y_q4) * 30'(DIV25_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_yr;
      t_c100_q <= prod_t[DIV_SH+7:DIV_SH];
      y_q4_q   <= y_q4;
      y_c100_q <= prod_y[DIV_SH+7:DIV_SH];
      y_lo_q   <= date_i.year[1:0];
      month_q  <= date_i.month;
      day_q    <= date_i.day;
    end
  end

  // Stage B: leap rule, month check and the day number sum
  logic              div4, div100, div400, leap;
  logic [12:0]       y_back;
  logic [7:0]        t_c400;
  logic              date_ok;
  logic [DNUM_W-1:0] dnum;
  day_res_t          res_q;

  always_comb begin
    y_back  = 13'(y_c100_q) * 13'd25;
    div4    = (y_lo_q == 2'd0);
    div100  = div4 && (y_back == {1'b0, y_q4_q});
    div400  = div100 && (y_c100_q[1:0] == 2'd0);
    leap    = div4 && (!div100 || div400);
    t_c400  = {2'b00, t_c100_q[7:2]};
    date_ok = (month_q >= MON_JAN) && (month_q <= MON_DEC) &&
              (day_q != '0) && (day_q <= month_len(month_q, leap));
    dnum    = DNUM_W'(t_q) * DNUM_W'(365)
            + DNUM_W'(t_q[14:2])
            - DNUM_W'(t_c100_q)
            + DNUM_W'(t_c400)
            + DNUM_W'(days_before(month_q))
            + DNUM_W'((month_q > MON_FEB) && leap)
            + DNUM_W'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.dnum <= dnum;
      res_q.bad  <= !date_ok;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/dpod_merge.sv -----
// Merge stage: combines the four day numbers into the overlap count.
// Two register stages; depends on dpod_pkg.
module dpod_merge import dpod_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  day_res_t           lane_i [LANES],
  output logic [COUNT_W-1:0] overlap_days_o,
  output logic               bad_date_o
);

  // Stage 1: overlap test and choice of the shorter period
  logic [DNUM_W-1:0] s1, e1, s2, e2, len1, len2;
  logic              any_bad, disjoint, pick_first;

  logic [DNUM_W-1:0] cs_q, ce_q, os_q, oe_q;
  logic              live_q, bad_q;

  always_comb begin
    s1         = lane_i[0].dnum;
    e1         = lane_i[1].dnum;
    s2         = lane_i[2].dnum;
    e2         = lane_i[3].dnum;
    any_bad    = lane_i[0].bad || lane_i[1].bad || lane_i[2].bad || lane_i[3].bad;
    disjoint   = (e1 < s2) || (e2 < s1);
    len1       = (e1 > s1) ? e1 - s1 : '0;
    len2       = (e2 > s2) ? e2 - s2 : '0;
    pick_first = len1 < len2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q   <= pick_first ? s1 : s2;
      ce_q   <= pick_first ? e1 : e2;
      os_q   <= pick_first ? s2 : s1;
      oe_q   <= pick_first ? e2 : e1;
      live_q <= !any_bad && !disjoint;
      bad_q  <= any_bad;
    end
  end

  // Stage 2: clip [cs, ce-1] against [os, oe] and saturate
  logic [DNUM_W-1:0]  lo, hi, ce_m1;
  logic [DNUM_W:0]    span;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_q;
  logic               bad_out_q;

  always_comb begin
    ce_m1 = ce_q - DNUM_W'(1);
    lo    = (cs_q > os_q) ? cs_q : os_q;
    hi    = (ce_m1 < oe_q) ? ce_m1 : oe_q;
    span  = {1'b0, hi} - {1'b0, lo} + (DNUM_W+1)'(1);
    cnt   = '0;
    if (live_q && (ce_q > cs_q) && (hi >= lo)) begin
      cnt = (span > (DNUM_W+1)'(COUNT_MAX)) ? COUNT_MAX : span[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q     <= cnt;
      bad_out_q <= bad_q;
    end
  end

  assign overlap_days_o = cnt_q;
  assign bad_date_o     = bad_out_q;

endmodule

// ----- rtl/date_period_overlap_days.sv -----
// Top level of the date period overlap counter.
// Depends on dpod_pkg, dpod_in_if, dpod_out_if, dpod_date_lane and dpod_merge.
//
// Usage:
//   in_i carries one beat per pair of periods (first/second, start/end dates).
//   out_o returns one beat per input beat: overlap_days and bad_date.
//   Four date lanes convert the dates to day numbers side by side, then a
//   merge unit picks the shorter period and clips it against the other one.
// Pipeline: an accepted input beat passes two lane stages, then two merge
//   stages, before it leaves as its output beat.
// Throughput: one beat per cycle while out_o is not held; a new beat enters
//   while earlier ones are still in the lanes or the merge unit.
// Stall: the pipeline advances as a whole whenever the output register is
//   empty or being taken; while out_o is held, in_i.ready is low and every
//   stage holds its beat.
// Reset: rst_ni clears the stage valid bits only; the pipeline is empty and
//   in_i.ready is high right after reset. No configuration, no stored state.
module date_period_overlap_days import dpod_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dpod_in_if.sink    in_i,
  dpod_out_if.source out_o
);

  logic              en;
  logic [STAGES-1:0] vld_q, vld_d;
  date_t             dates [LANES];
  day_res_t          lane_res [LANES];

  // Advance the whole pipeline when the output slot frees up
  assign en         = !vld_q[STAGES-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    vld_d = vld_q;
    if (en) begin
      vld_d = {vld_q[STAGES-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Route the four dates to their lanes
  assign dates[0] = '{in_i.first_start_year,  in_i.first_start_month,  in_i.first_start_day};
  assign dates[1] = '{in_i.first_end_year,    in_i.first_end_month,    in_i.first_end_day};
  assign dates[2] = '{in_i.second_start_year, in_i.second_start_month, in_i.second_start_day};
  assign dates[3] = '{in_i.second_end_year,   in_i.second_end_month,   in_i.second_end_day};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dpod_date_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .date_i (dates[g]),
      .res_o  (lane_res[g])
    );
  end

  dpod_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (en),
    .lane_i         (lane_res),
    .overlap_days_o (out_o.overlap_days),
    .bad_date_o     (out_o.bad_date)
  );

  assign out_o.valid = vld_q[STAGES-1];

  // A flagged date always reports an empty overlap
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_date) |-> (out_o.overlap_days == '0))
    else $error("bad_date beat with nonzero overlap count");

  // An output beat only appears after the previous stage held a beat
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(vld_q[STAGES-2]))
    else $error("output beat appeared from an empty stage");

  // An empty pipeline with no new beat stays empty at the output
  a_empty_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q == '0) && !in_i.valid) |=> !out_o.valid)
    else $error("output valid without any beat in flight");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for date_period_overlap_days: drives period pairs, predicts each overlap count.
// Depends on dpod_pkg, dpod_in_if, dpod_out_if and the date_period_overlap_days RTL.

module tb_top import dpod_pkg::*; ();

  typedef struct packed {
    date_t first_start;
    date_t first_end;
    date_t second_start;
    date_t second_end;
  } period_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0] days;
    logic               bad;
  } overlap_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_e;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned YEAR_TOP     = (1 << YEAR_W) - 1;

  logic clk = 1'b0;
  logic rst_ni;

  dpod_in_if  in_bus ();
  dpod_out_if out_bus ();

  date_period_overlap_days dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  overlap_t pending_counts[$];
  int unsigned n_errors    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_bad_dates = 0;
  int unsigned n_zero      = 0;
  int unsigned n_saturated = 0;
  int unsigned burst_left  = 0;
  bit          steady_send = 1'b0;
  int unsigned hold_requests = 0;

  always #1 clk = ~clk;

  // Calendar arithmetic for the predictor

  function automatic bit is_leap(input logic [YEAR_W-1:0] y);
    int unsigned yy;
    yy = y;
    return (yy % 400 == 0) || ((yy % 100 != 0) && (yy % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] m,
                                                input logic [YEAR_W-1:0] y);
    if (m == MON_FEB) return is_leap(y) ? 29 : 28;
    if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(input date_t d);
    if (d.month < MON_JAN || d.month > MON_DEC) return 1'b0;
    return (d.day >= 1) && (d.day <= days_in_month(d.month, d.year));
  endfunction

  function automatic int unsigned days_ahead_of_month(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    return 31;
      4'd3:    return 59;
      4'd4:    return 90;
      4'd5:    return 120;
      4'd6:    return 151;
      4'd7:    return 181;
      4'd8:    return 212;
      4'd9:    return 243;
      4'd10:   return 273;
      4'd11:   return 304;
      4'd12:   return 334;
      default: return 0;
    endcase
  endfunction

  // Day count since a fixed epoch; the year is shifted by 399 so year 0 fits
  function automatic int unsigned day_count(input date_t d);
    int unsigned t;
    int unsigned n;
    t = d.year + 399;
    n = 365 * t + t / 4 - t / 100 + t / 400 + days_ahead_of_month(d.month);
    if (d.month > MON_FEB && is_leap(d.year)) n = n + 1;
    return n + d.day;
  endfunction

  // Overlap of the shorter period (end exclusive) with the other (end inclusive)
  function automatic overlap_t predict_overlap(input period_pair_t p);
    overlap_t    r;
    int unsigned s1, e1, s2, e2, l1, l2, cs, ce, os, oe, lo, hi, cnt;
    r.days = '0;
    r.bad  = 1'b0;
    if (!date_valid(p.first_start) || !date_valid(p.first_end) ||
        !date_valid(p.second_start) || !date_valid(p.second_end)) begin
      r.bad = 1'b1;
      return r;
    end
    s1  = day_count(p.first_start);
    e1  = day_count(p.first_end);
    s2  = day_count(p.second_start);
    e2  = day_count(p.second_end);
    cnt = 0;
    if (!(e1 < s2) && !(e2 < s1)) begin
      l1 = (e1 > s1) ? e1 - s1 : 0;
      l2 = (e2 > s2) ? e2 - s2 : 0;
      if (l1 < l2) begin
        cs = s1; ce = e1; os = s2; oe = e2;
      end else begin
        cs = s2; ce = e2; os = s1; oe = e1;
      end
      if (ce > cs) begin
        lo = (cs > os) ? cs : os;
        hi = (ce - 1 < oe) ? ce - 1 : oe;
        if (hi >= lo) cnt = hi - lo + 1;
      end
    end
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    r.days = cnt[COUNT_W-1:0];
    return r;
  endfunction

  // Item builders

  function automatic date_t make_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
    date_t r;
    r.year  = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day   = d[DAY_W-1:0];
    return r;
  endfunction

  function automatic period_pair_t make_pair(input date_t a, input date_t b,
                                             input date_t c, input date_t d);
    period_pair_t p;
    p.first_start  = a;
    p.first_end    = b;
    p.second_start = c;
    p.second_end   = d;
    return p;
  endfunction

  function automatic date_t any_valid_date(input int unsigned y_lo, input int unsigned y_hi);
    date_t d;
    d.year  = YEAR_W'($urandom_range(y_hi, y_lo));
    d.month = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
    d.day   = DAY_W'($urandom_range(days_in_month(d.month, d.year), 1));
    return d;
  endfunction

  // Mostly well-formed periods close together, some linked, some with a broken date
  function automatic period_pair_t rand_pair();
    date_t       lane[4];
    date_t       tmp;
    int unsigned kind, base, span, top, i;
    kind = $urandom_range(99, 0);
    span = ($urandom_range(9, 0) == 0) ? $urandom_range(4000, 3) : $urandom_range(2, 0);
    base = ($urandom_range(19, 0) == 0) ? $urandom_range(YEAR_TOP, 0) : $urandom_range(9999, 1);
    top  = (base + span > YEAR_TOP) ? YEAR_TOP : base + span;
    if (kind >= 70 && kind < 85) begin
      base = 0;
      top  = YEAR_TOP;
    end
    for (i = 0; i < 4; i++) lane[i] = any_valid_date(base, top);
    // order each period start-to-end most of the time
    for (i = 0; i < 4; i += 2) begin
      if (day_count(lane[i]) > day_count(lane[i+1]) && $urandom_range(99, 0) < 85) begin
        tmp       = lane[i];
        lane[i]   = lane[i+1];
        lane[i+1] = tmp;
      end
    end
    if (kind < 70) begin
      // link the periods: touching ends, tie, shared start
      case ($urandom_range(9, 0))
        0: lane[2] = lane[1];
        1: lane[3] = lane[0];
        2: begin
          lane[2] = lane[0];
          lane[3] = lane[1];
        end
        3: lane[2] = lane[0];
        default: ;
      endcase
    end else if (kind >= 85) begin
      // break one date with raw month and day bits
      i = $urandom_range(3, 0);
      lane[i].month = MONTH_W'($urandom_range(15, 0));
      lane[i].day   = DAY_W'($urandom_range(31, 0));
    end
    return make_pair(lane[0], lane[1], lane[2], lane[3]);
  endfunction

  // Sender: one beat per call, in bursts with random gaps
  task automatic offer_periods(input period_pair_t p);
    int unsigned gap;
    if (burst_left == 0 && !steady_send) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    if (burst_left != 0) burst_left--;
    in_bus.first_start_year   <= p.first_start.year;
    in_bus.first_start_month  <= p.first_start.month;
    in_bus.first_start_day    <= p.first_start.day;
    in_bus.first_end_year     <= p.first_end.year;
    in_bus.first_end_month    <= p.first_end.month;
    in_bus.first_end_day      <= p.first_end.day;
    in_bus.second_start_year  <= p.second_start.year;
    in_bus.second_start_month <= p.second_start.month;
    in_bus.second_start_day   <= p.second_start.day;
    in_bus.second_end_year    <= p.second_end.year;
    in_bus.second_end_month   <= p.second_end.month;
    in_bus.second_end_day     <= p.second_end.day;
    in_bus.valid              <= 1'b1;
    pending_counts.push_back(predict_overlap(p));
    do @(posedge clk); while (!in_bus.ready);
    n_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_until_settled();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // Corners: field extremes, leap rules, bad dates, disjoint, touching, ties, saturation
  task automatic run_directed_corners();
    period_pair_t corners[$];
    corners.push_back(make_pair(make_date(2000, 1, 1), make_date(2000, 1, 31),
                                make_date(2000, 1, 1), make_date(2000, 1, 31)));
    corners.push_back(make_pair(make_date(2020, 1, 1), make_date(2020, 12, 31),
                                make_date(2020, 6, 1), make_date(2020, 6, 10)));
    corners.push_back(make_pair(make_date(2020, 3, 1), make_date(2020, 3, 5),
                                make_date(2019, 1, 1), make_date(2021, 1, 1)));
    corners.push_back(make_pair(make_date(2019, 12, 20), make_date(2020, 1, 5),
                                make_date(2020, 1, 1), make_date(2020, 2, 29)));
    corners.push_back(make_pair(make_date(2001, 1, 1), make_date(2001, 1, 2),
                                make_date(2001, 1, 3), make_date(2001, 2, 1)));
    corners.push_back(make_pair(make_date(2001, 3, 3), make_date(2001, 4, 1),
                                make_date(2001, 1, 1), make_date(2001, 3, 2)));
    corners.push_back(make_pair(make_date(2010, 1, 1), make_date(2010, 1, 10),
                                make_date(2010, 1, 10), make_date(2010, 2, 10)));
    corners.push_back(make_pair(make_date(2010, 2, 10), make_date(2010, 3, 10),
                                make_date(2010, 1, 1), make_date(2010, 2, 10)));
    corners.push_back(make_pair(make_date(2015, 5, 10), make_date(2015, 5, 1),
                                make_date(2015, 5, 1), make_date(2015, 5, 20)));
    corners.push_back(make_pair(make_date(2015, 5, 20), make_date(2015, 5, 1),
                                make_date(2015, 5, 15), make_date(2015, 5, 3)));
    corners.push_back(make_pair(make_date(2015, 6, 15), make_date(2015, 6, 15),
                                make_date(2015, 6, 1), make_date(2015, 6, 30)));
    corners.push_back(make_pair(make_date(1900, 1, 1), make_date(1900, 3, 1),
                                make_date(1900, 2, 1), make_date(1900, 2, 29)));
    corners.push_back(make_pair(make_date(0, 2, 29), make_date(2000, 2, 29),
                                make_date(1600, 2, 29), make_date(2400, 2, 29)));
    corners.push_back(make_pair(make_date(2021, 2, 30), make_date(2021, 3, 1),
                                make_date(2021, 1, 1), make_date(2021, 12, 31)));
    corners.push_back(make_pair(make_date(2021, 1, 1), make_date(2021, MON_APR, 31),
                                make_date(2021, 1, 1), make_date(2021, 12, 31)));
    corners.push_back(make_pair(make_date(2021, 1, 1), make_date(2021, 2, 1),
                                make_date(2021, 1, 0), make_date(2021, 12, 31)));
    corners.push_back(make_pair(make_date(2021, 0, 1), make_date(2021, 2, 1),
                                make_date(2021, 1, 1), make_date(2021, 12, 31)));
    corners.push_back(make_pair(make_date(2021, 1, 1), make_date(2021, 2, 1),
                                make_date(2021, 1, 1), make_date(2021, 13, 1)));
    corners.push_back(make_pair(make_date(YEAR_TOP, 15, 31), make_date(0, 0, 0),
                                make_date(YEAR_TOP, 15, 31), make_date(0, 0, 0)));
    corners.push_back(make_pair(make_date(1, 1, 1), make_date(9999, 12, 31),
                                make_date(9999, 12, 31), make_date(YEAR_TOP, 12, 31)));
    corners.push_back(make_pair(make_date(0, 1, 1), make_date(YEAR_TOP, 12, 31),
                                make_date(0, 1, 1), make_date(YEAR_TOP, 12, 31)));
    corners.push_back(make_pair(make_date(0, 1, 1), make_date(YEAR_TOP, 12, 31),
                                make_date(5, 1, 1), make_date(YEAR_TOP, 12, 31)));
    corners.push_back(make_pair(make_date(YEAR_TOP, 12, 31), make_date(YEAR_TOP, 12, 31),
                                make_date(YEAR_TOP, 12, 31), make_date(YEAR_TOP, 12, 31)));
    foreach (corners[i]) offer_periods(corners[i]);
  endtask

  task automatic run_random_periods(input int unsigned count);
    repeat (count) offer_periods(rand_pair());
  endtask

  // Hold the output while the sender keeps offering, so the pipeline fills and stalls
  task automatic run_output_holdoff();
    steady_send = 1'b1;
    hold_requests++;
    run_random_periods(60);
    steady_send = 1'b0;
  endtask

  // Receiver: stall pattern that changes mode now and then, plus requested hold-offs
  rx_mode_e    rx_mode    = RX_OPEN;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;
  logic [7:0]  stall_mask = 8'b1011_0010;

  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(3, 0));
        mode_left <= $urandom_range(256, 32);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_COIN:   out_bus.ready <= 1'($urandom_range(1, 0));
        RX_SPARSE: out_bus.ready <= ($urandom_range(3, 0) == 0);
        default: begin
          out_bus.ready <= stall_mask[0];
          stall_mask    <= {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  task automatic report_mismatch(input string what, input overlap_t want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t: %s: expected days=%0d bad=%0b, got days=%0d bad=%0b", $realtime, what,
               want.days, want.bad, out_bus.overlap_days, out_bus.bad_date);
  endtask

  // Compare every result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    overlap_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_counts.size() == 0) begin
        want = '0;
        report_mismatch("result beat with nothing outstanding", want);
      end else begin
        want = pending_counts.pop_front();
        n_checked++;
        if (want.bad) n_bad_dates++;
        else if (want.days == 0) n_zero++;
        else if (want.days == COUNT_MAX) n_saturated++;
        if (out_bus.overlap_days !== want.days) report_mismatch("overlap_days mismatch", want);
        if (out_bus.bad_date !== want.bad) report_mismatch("bad_date mismatch", want);
      end
    end
  end

  initial begin
    #1_500_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_ni                    = 1'b0;
    out_bus.ready             = 1'b0;
    in_bus.valid              = 1'b0;
    in_bus.first_start_year   = '0;
    in_bus.first_start_month  = '0;
    in_bus.first_start_day    = '0;
    in_bus.first_end_year     = '0;
    in_bus.first_end_month    = '0;
    in_bus.first_end_day      = '0;
    in_bus.second_start_year  = '0;
    in_bus.second_start_month = '0;
    in_bus.second_start_day   = '0;
    in_bus.second_end_year    = '0;
    in_bus.second_end_month   = '0;
    in_bus.second_end_day     = '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    run_directed_corners();
    wait_until_settled();
    run_random_periods(900);
    run_output_holdoff();
    wait_until_settled();
    run_random_periods(1000);
    wait_until_settled();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d period pairs, checked %0d results: %0d bad dates, %0d zero, %0d saturated.",
             n_sent, n_checked, n_bad_dates, n_zero, n_saturated);
    $display("Covered calendar corners, random periods over all years, output hold-off, drains.");
    if (n_errors == 0 && pending_counts.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
